[hw/rtl/pgpsig_pkg.sv]
// ----------------------------------------------------------------------------
// pgpsig_pkg
// Types and codes shared by the version-4 signature packet parser: the
// transaction structs of both channels, the parser phases, field tags,
// error codes, public-key algorithm numbers and subpacket length codes.
// ----------------------------------------------------------------------------
package pgpsig_pkg;

  // Input transaction: one byte of the packet body
  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_last;
  } byte_t;

  // Result transaction: the byte and its tags
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  field_kind;
    logic [31:0] subpacket_length;
    logic        subpacket_first;
    logic        subpacket_end;
    logic        mpi_number;
    logic [13:0] mpi_byte_count;
    logic [1:0]  error_code;
    logic        packet_done;
  } tag_t;

  // Parser phases. Each subpacket area owns four: header start, second
  // octet of a two-octet length, octets of a five-octet length, body.
  typedef enum logic [4:0] {
    PH_VER    = 5'd0,
    PH_TYPE   = 5'd1,
    PH_PK     = 5'd2,
    PH_HASH   = 5'd3,
    PH_HLEN0  = 5'd4,
    PH_HLEN1  = 5'd5,
    PH_HSTART = 5'd6,
    PH_HHDR2  = 5'd7,
    PH_HHDR5  = 5'd8,
    PH_HBODY  = 5'd9,
    PH_ULEN0  = 5'd10,
    PH_ULEN1  = 5'd11,
    PH_USTART = 5'd12,
    PH_UHDR2  = 5'd13,
    PH_UHDR5  = 5'd14,
    PH_UBODY  = 5'd15,
    PH_FRAG0  = 5'd16,
    PH_FRAG1  = 5'd17,
    PH_MLEN0  = 5'd18,
    PH_MLEN1  = 5'd19,
    PH_MDATA  = 5'd20,
    PH_TRAIL  = 5'd21,
    PH_HALT   = 5'd22
  } phase_t;

  // Field tags
  localparam logic [3:0] KIND_VERSION     = 4'd0;
  localparam logic [3:0] KIND_TYPE        = 4'd1;
  localparam logic [3:0] KIND_PK_ALGO     = 4'd2;
  localparam logic [3:0] KIND_HASH_ALGO   = 4'd3;
  localparam logic [3:0] KIND_HASHED_LEN  = 4'd4;
  localparam logic [3:0] KIND_HASHED_HDR  = 4'd5;
  localparam logic [3:0] KIND_HASHED_BODY = 4'd6;
  localparam logic [3:0] KIND_UNHASH_LEN  = 4'd7;
  localparam logic [3:0] KIND_UNHASH_HDR  = 4'd8;
  localparam logic [3:0] KIND_UNHASH_BODY = 4'd9;
  localparam logic [3:0] KIND_FRAGMENT    = 4'd10;
  localparam logic [3:0] KIND_MPI_LEN     = 4'd11;
  localparam logic [3:0] KIND_MPI_DATA    = 4'd12;
  localparam logic [3:0] KIND_IGNORED     = 4'd13;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_EARLY   = 2'd2;
  localparam logic [1:0] ERR_ALGO    = 2'd3;

  // Public-key algorithms
  localparam logic [7:0] ALG_RSA_ANY  = 8'd1;
  localparam logic [7:0] ALG_RSA_SIGN = 8'd3;
  localparam logic [7:0] ALG_DSA      = 8'd17;

  // Subpacket length encoding
  localparam logic [7:0] LEN_TWO_MIN  = 8'd192;
  localparam logic [7:0] LEN_FIVE_TAG = 8'hff;
  localparam logic [2:0] LEN_FIVE_CNT = 3'd4;

endpackage

[hw/rtl/pgp_signature_packet_parser.sv]
// ----------------------------------------------------------------------------
// pgp_signature_packet_parser
// Streaming tagger for the body of a version-4 signature packet.
// ----------------------------------------------------------------------------
// Takes one packet-body byte per transaction and returns exactly one result
// per byte: the byte with its field tag, decoded subpacket and MPI lengths,
// the latched error code and an end-of-packet flag. It takes one byte per
// clock unless a held result is stalled, and each result is registered on
// acceptance. The parser state is updated by a single pass of logic per
// byte; the result register takes a new byte in the cycle the previous
// result leaves, so byte_stall rises only when a held result is stalled.
// After the byte marked body_last all state returns to its reset value.
// After an error every further byte is tagged ignored until body_last.
// ----------------------------------------------------------------------------
module pgp_signature_packet_parser (
  input  logic              clk,
  input  logic              rst,
  // byte input channel
  input  logic              byte_valid,
  output logic              byte_stall,
  input  pgpsig_pkg::byte_t byte_data,
  // result channel
  output logic              tag_valid,
  input  logic              tag_stall,
  output pgpsig_pkg::tag_t  tag_data
);

  // State registers
  pgpsig_pkg::phase_t phase, phase_next;
  logic [15:0] area_left, area_left_next;
  logic [31:0] subpacket_left, subpacket_left_next;
  logic [31:0] length_gather, length_gather_next;
  logic [2:0]  header_bytes_seen, header_bytes_seen_next;
  logic [7:0]  pk_algorithm, pk_algorithm_next;
  logic [13:0] mpi_left, mpi_left_next;
  logic        current_mpi, current_mpi_next;
  logic [1:0]  error_latch, error_latch_next;
  logic [1:0]  error_out;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  pgpsig_pkg::tag_t tag_next;

  // Shared decode helpers
  logic        hashed;
  pgpsig_pkg::phase_t ph_start, ph_after, ph_body, ph_hdr2, ph_hdr5;
  logic [15:0] area_dec;
  logic [31:0] sub_dec;
  logic [13:0] mpi_dec;
  logic        hdr_done;
  logic [31:0] hdr_len;
  logic [2:0]  hbs_inc;
  logic [16:0] mpi_bits7;
  logic [13:0] mpi_len;
  logic        algo_ok;
  logic        dsa_more;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = tag_valid && tag_stall;
  assign b          = byte_data.in_byte;
  assign last       = byte_data.body_last;

  // Area selection and arithmetic shared by both blocks
  always_comb begin
    hashed   = (phase == pgpsig_pkg::PH_HSTART) || (phase == pgpsig_pkg::PH_HHDR2) ||
               (phase == pgpsig_pkg::PH_HHDR5)  || (phase == pgpsig_pkg::PH_HBODY);
    ph_start = hashed ? pgpsig_pkg::PH_HSTART : pgpsig_pkg::PH_USTART;
    ph_after = hashed ? pgpsig_pkg::PH_ULEN0  : pgpsig_pkg::PH_FRAG0;
    ph_body  = hashed ? pgpsig_pkg::PH_HBODY  : pgpsig_pkg::PH_UBODY;
    ph_hdr2  = hashed ? pgpsig_pkg::PH_HHDR2  : pgpsig_pkg::PH_UHDR2;
    ph_hdr5  = hashed ? pgpsig_pkg::PH_HHDR5  : pgpsig_pkg::PH_UHDR5;
    area_dec = area_left - 16'd1;
    sub_dec  = subpacket_left - 32'd1;
    mpi_dec  = mpi_left - 14'd1;
    hbs_inc  = header_bytes_seen + 3'd1;
    mpi_bits7 = {1'b0, length_gather[15:8], b} + 17'd7;
    mpi_len   = mpi_bits7[16:3];
    algo_ok  = (pk_algorithm == pgpsig_pkg::ALG_RSA_ANY) ||
               (pk_algorithm == pgpsig_pkg::ALG_RSA_SIGN) ||
               (pk_algorithm == pgpsig_pkg::ALG_DSA);
    dsa_more = (pk_algorithm == pgpsig_pkg::ALG_DSA) && !current_mpi;
  end

  // Subpacket length header completion
  always_comb begin
    hdr_done = 1'b0;
    hdr_len  = 32'd0;
    case (phase)
      pgpsig_pkg::PH_HSTART, pgpsig_pkg::PH_USTART: begin
        if (b < pgpsig_pkg::LEN_TWO_MIN) begin
          hdr_done = 1'b1;
          hdr_len  = {24'd0, b};
        end
      end
      pgpsig_pkg::PH_HHDR2, pgpsig_pkg::PH_UHDR2: begin
        hdr_done = 1'b1;
        hdr_len  = length_gather + {24'd0, b} + {24'd0, pgpsig_pkg::LEN_TWO_MIN};
      end
      pgpsig_pkg::PH_HHDR5, pgpsig_pkg::PH_UHDR5: begin
        hdr_done = (hbs_inc >= pgpsig_pkg::LEN_FIVE_CNT);
        hdr_len  = {length_gather[23:0], b};
      end
      default: begin
        hdr_done = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next             = phase;
    area_left_next         = area_left;
    subpacket_left_next    = subpacket_left;
    length_gather_next     = length_gather;
    header_bytes_seen_next = header_bytes_seen;
    pk_algorithm_next      = pk_algorithm;
    mpi_left_next          = mpi_left;
    current_mpi_next       = current_mpi;
    error_latch_next       = error_latch;

    unique case (phase)
      pgpsig_pkg::PH_VER:  phase_next = pgpsig_pkg::PH_TYPE;
      pgpsig_pkg::PH_TYPE: phase_next = pgpsig_pkg::PH_PK;
      pgpsig_pkg::PH_PK: begin
        pk_algorithm_next = b;
        phase_next        = pgpsig_pkg::PH_HASH;
      end
      pgpsig_pkg::PH_HASH: phase_next = pgpsig_pkg::PH_HLEN0;
      pgpsig_pkg::PH_HLEN0: begin
        area_left_next = {b, 8'h00};
        phase_next     = pgpsig_pkg::PH_HLEN1;
      end
      pgpsig_pkg::PH_ULEN0: begin
        area_left_next = {b, 8'h00};
        phase_next     = pgpsig_pkg::PH_ULEN1;
      end
      pgpsig_pkg::PH_HLEN1: begin
        area_left_next = {area_left[15:8], b};
        phase_next = ({area_left[15:8], b} == 16'd0) ? pgpsig_pkg::PH_ULEN0
                                                     : pgpsig_pkg::PH_HSTART;
      end
      pgpsig_pkg::PH_ULEN1: begin
        area_left_next = {area_left[15:8], b};
        phase_next = ({area_left[15:8], b} == 16'd0) ? pgpsig_pkg::PH_FRAG0
                                                     : pgpsig_pkg::PH_USTART;
      end
      pgpsig_pkg::PH_HSTART, pgpsig_pkg::PH_USTART,
      pgpsig_pkg::PH_HHDR2, pgpsig_pkg::PH_UHDR2,
      pgpsig_pkg::PH_HHDR5, pgpsig_pkg::PH_UHDR5: begin
        area_left_next = area_dec;
        if (hdr_done) begin
          length_gather_next = hdr_len;
          if (hdr_len > {16'd0, area_dec}) begin
            phase_next       = pgpsig_pkg::PH_HALT;
            error_latch_next = pgpsig_pkg::ERR_OVERRUN;
          end else if (hdr_len == 32'd0) begin
            phase_next = (area_dec == 16'd0) ? ph_after : ph_start;
          end else begin
            subpacket_left_next = hdr_len;
            phase_next          = ph_body;
          end
        end else begin
          // header continues: start of a long form or inside a five-octet one
          if (phase == ph_start) begin
            header_bytes_seen_next = 3'd0;
            if (b == pgpsig_pkg::LEN_FIVE_TAG) begin
              length_gather_next = 32'd0;
              phase_next         = ph_hdr5;
            end else begin
              length_gather_next = {16'd0, b - pgpsig_pkg::LEN_TWO_MIN, 8'h00};
              phase_next         = ph_hdr2;
            end
            if (b != pgpsig_pkg::LEN_FIVE_TAG) begin
              header_bytes_seen_next = header_bytes_seen;
            end
          end else begin
            length_gather_next     = hdr_len;
            header_bytes_seen_next = hbs_inc;
          end
          if (area_dec == 16'd0) begin
            phase_next       = pgpsig_pkg::PH_HALT;
            error_latch_next = pgpsig_pkg::ERR_OVERRUN;
          end
        end
      end
      pgpsig_pkg::PH_HBODY, pgpsig_pkg::PH_UBODY: begin
        area_left_next      = area_dec;
        subpacket_left_next = sub_dec;
        if (sub_dec == 32'd0) begin
          phase_next = (area_dec == 16'd0) ? ph_after : ph_start;
        end
      end
      pgpsig_pkg::PH_FRAG0: phase_next = pgpsig_pkg::PH_FRAG1;
      pgpsig_pkg::PH_FRAG1: begin
        if (algo_ok) begin
          current_mpi_next = 1'b0;
          phase_next       = pgpsig_pkg::PH_MLEN0;
        end else begin
          phase_next       = pgpsig_pkg::PH_HALT;
          error_latch_next = pgpsig_pkg::ERR_ALGO;
        end
      end
      pgpsig_pkg::PH_MLEN0: begin
        length_gather_next = {16'd0, b, 8'h00};
        phase_next         = pgpsig_pkg::PH_MLEN1;
      end
      pgpsig_pkg::PH_MLEN1: begin
        length_gather_next = {18'd0, mpi_len};
        mpi_left_next      = mpi_len;
        if (mpi_len != 14'd0) begin
          phase_next = pgpsig_pkg::PH_MDATA;
        end else if (dsa_more) begin
          current_mpi_next = 1'b1;
          phase_next       = pgpsig_pkg::PH_MLEN0;
        end else begin
          phase_next = pgpsig_pkg::PH_TRAIL;
        end
      end
      pgpsig_pkg::PH_MDATA: begin
        mpi_left_next = mpi_dec;
        if (mpi_dec == 14'd0) begin
          if (dsa_more) begin
            current_mpi_next = 1'b1;
            phase_next       = pgpsig_pkg::PH_MLEN0;
          end else begin
            phase_next = pgpsig_pkg::PH_TRAIL;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // early end, reported on this byte
    if (last && (phase_next != pgpsig_pkg::PH_TRAIL) &&
        (error_latch_next == pgpsig_pkg::ERR_NONE)) begin
      error_latch_next = pgpsig_pkg::ERR_EARLY;
    end
    error_out = error_latch_next;

    // end of packet: back to reset values
    if (last) begin
      phase_next             = pgpsig_pkg::PH_VER;
      area_left_next         = 16'd0;
      subpacket_left_next    = 32'd0;
      length_gather_next     = 32'd0;
      header_bytes_seen_next = 3'd0;
      pk_algorithm_next      = 8'd0;
      mpi_left_next          = 14'd0;
      current_mpi_next       = 1'b0;
      error_latch_next       = pgpsig_pkg::ERR_NONE;
    end
  end

  // Result fields
  always_comb begin
    tag_next                  = '0;
    tag_next.out_byte         = b;
    tag_next.field_kind       = pgpsig_pkg::KIND_IGNORED;
    tag_next.error_code       = error_out;
    tag_next.packet_done      = last;

    unique case (phase)
      pgpsig_pkg::PH_VER:   tag_next.field_kind = pgpsig_pkg::KIND_VERSION;
      pgpsig_pkg::PH_TYPE:  tag_next.field_kind = pgpsig_pkg::KIND_TYPE;
      pgpsig_pkg::PH_PK:    tag_next.field_kind = pgpsig_pkg::KIND_PK_ALGO;
      pgpsig_pkg::PH_HASH:  tag_next.field_kind = pgpsig_pkg::KIND_HASH_ALGO;
      pgpsig_pkg::PH_HLEN0, pgpsig_pkg::PH_HLEN1:
        tag_next.field_kind = pgpsig_pkg::KIND_HASHED_LEN;
      pgpsig_pkg::PH_ULEN0, pgpsig_pkg::PH_ULEN1:
        tag_next.field_kind = pgpsig_pkg::KIND_UNHASH_LEN;
      pgpsig_pkg::PH_HSTART, pgpsig_pkg::PH_USTART,
      pgpsig_pkg::PH_HHDR2, pgpsig_pkg::PH_UHDR2,
      pgpsig_pkg::PH_HHDR5, pgpsig_pkg::PH_UHDR5: begin
        tag_next.field_kind = hashed ? pgpsig_pkg::KIND_HASHED_HDR
                                     : pgpsig_pkg::KIND_UNHASH_HDR;
        if (hdr_done) begin
          tag_next.subpacket_length = hdr_len;
        end
      end
      pgpsig_pkg::PH_HBODY, pgpsig_pkg::PH_UBODY: begin
        tag_next.field_kind = hashed ? pgpsig_pkg::KIND_HASHED_BODY
                                     : pgpsig_pkg::KIND_UNHASH_BODY;
        tag_next.subpacket_length = length_gather;
        tag_next.subpacket_first  = (subpacket_left == length_gather);
        tag_next.subpacket_end    = (subpacket_left == 32'd1);
      end
      pgpsig_pkg::PH_FRAG0, pgpsig_pkg::PH_FRAG1:
        tag_next.field_kind = pgpsig_pkg::KIND_FRAGMENT;
      pgpsig_pkg::PH_MLEN0: begin
        tag_next.field_kind = pgpsig_pkg::KIND_MPI_LEN;
        tag_next.mpi_number = current_mpi;
      end
      pgpsig_pkg::PH_MLEN1: begin
        tag_next.field_kind     = pgpsig_pkg::KIND_MPI_LEN;
        tag_next.mpi_number     = current_mpi;
        tag_next.mpi_byte_count = mpi_len;
      end
      pgpsig_pkg::PH_MDATA: begin
        tag_next.field_kind     = pgpsig_pkg::KIND_MPI_DATA;
        tag_next.mpi_number     = current_mpi;
        tag_next.mpi_byte_count = length_gather[13:0];
      end
      default: begin
        tag_next.field_kind = pgpsig_pkg::KIND_IGNORED;
      end
    endcase
  end

  // Parser state, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= pgpsig_pkg::PH_VER;
      area_left         <= 16'd0;
      subpacket_left    <= 32'd0;
      length_gather     <= 32'd0;
      header_bytes_seen <= 3'd0;
      pk_algorithm      <= 8'd0;
      mpi_left          <= 14'd0;
      current_mpi       <= 1'b0;
      error_latch       <= pgpsig_pkg::ERR_NONE;
    end else if (accept) begin
      phase             <= phase_next;
      area_left         <= area_left_next;
      subpacket_left    <= subpacket_left_next;
      length_gather     <= length_gather_next;
      header_bytes_seen <= header_bytes_seen_next;
      pk_algorithm      <= pk_algorithm_next;
      mpi_left          <= mpi_left_next;
      current_mpi       <= current_mpi_next;
      error_latch       <= error_latch_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (accept) begin
      tag_valid <= 1'b1;
    end else if (!tag_stall) begin
      tag_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_data <= tag_next;
    end
  end

  // Assertions
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> phase == pgpsig_pkg::PH_VER)
    else $error("parser not back at version octet after body_last");

  a_halt_has_error: assert property (@(posedge clk) disable iff (rst)
    phase == pgpsig_pkg::PH_HALT |-> error_latch != pgpsig_pkg::ERR_NONE)
    else $error("parser halted without a latched error");

  a_mdata_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == pgpsig_pkg::PH_MDATA |-> mpi_left != 14'd0)
    else $error("MPI data phase with no bytes left");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> tag_valid)
    else $error("input stalled with no result held");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> tag_valid)
    else $error("accepted byte produced no result");

endmodule

[tb/sv/pgp_signature_packet_parser_tb.sv]
// ----------------------------------------------------------------------------
// pgp_signature_packet_parser_tb
// Self-checking bench for the version-4 signature packet parser.
// ----------------------------------------------------------------------------
// A short table of hand-built packets comes first: a clean RSA packet with an
// empty subpacket, a trailing byte and an empty area, then an unknown
// algorithm, an area overrun and a one-byte packet that ends early. Random
// packets follow: mostly well formed with random content, plus truncated,
// corrupted, oversized and noise packets. Each result is checked field by
// field against an in-bench parser model or a fixed row's tag. Both channels
// idle in random bursts; the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module pgp_signature_packet_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  pgpsig_pkg::byte_t byte_data  = '0;
  logic              tag_valid;
  logic              tag_stall  = 1'b0;
  pgpsig_pkg::tag_t  tag_data;

  pgp_signature_packet_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .tag_valid  (tag_valid),
    .tag_stall  (tag_stall),
    .tag_data   (tag_data)
  );

  // One row of the directed table
  typedef struct {
    logic [7:0]       b;
    logic             last;
    bit               fixed;
    pgpsig_pkg::tag_t want;
  } row_t;

  row_t              plan[$];
  pgpsig_pkg::byte_t pkt_q[$];
  pgpsig_pkg::tag_t  pending_tags[$];
  int    n_errors  = 0;
  int    n_results = 0;
  int    n_sent    = 0;
  bit    idle_on   = 1'b1;

  // Parser model state
  pgpsig_pkg::phase_t sig_phase;
  logic [15:0] area_rem;
  logic [31:0] sub_rem;
  logic [31:0] len_acc;
  logic [2:0]  len5_cnt;
  logic [7:0]  pk_algo;
  logic [13:0] mpi_rem;
  logic        mpi_idx;
  logic [1:0]  err_held;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void reset_parse();
    sig_phase = pgpsig_pkg::PH_VER;
    area_rem  = '0;
    sub_rem   = '0;
    len_acc   = '0;
    len5_cnt  = '0;
    pk_algo   = '0;
    mpi_rem   = '0;
    mpi_idx   = 1'b0;
    err_held  = pgpsig_pkg::ERR_NONE;
  endfunction

  // first error wins; parsing stops either way
  function automatic void halt_parse(logic [1:0] code);
    if (err_held == pgpsig_pkg::ERR_NONE) err_held = code;
    sig_phase = pgpsig_pkg::PH_HALT;
  endfunction

  function automatic void area_next(bit uh);
    if (area_rem == 0) sig_phase = uh ? pgpsig_pkg::PH_FRAG0 : pgpsig_pkg::PH_ULEN0;
    else sig_phase = uh ? pgpsig_pkg::PH_USTART : pgpsig_pkg::PH_HSTART;
  endfunction

  function automatic void header_done(bit uh, logic [31:0] len);
    len_acc = len;
    if (len > {16'h0, area_rem}) begin
      halt_parse(pgpsig_pkg::ERR_OVERRUN);
    end else if (len == 0) begin
      area_next(uh);
    end else begin
      sub_rem   = len;
      sig_phase = uh ? pgpsig_pkg::PH_UBODY : pgpsig_pkg::PH_HBODY;
    end
  endfunction

  // DSA carries r then s; RSA a single MPI
  function automatic void mpi_done();
    if (pk_algo == pgpsig_pkg::ALG_DSA && mpi_idx == 1'b0) begin
      mpi_idx   = 1'b1;
      sig_phase = pgpsig_pkg::PH_MLEN0;
    end else begin
      sig_phase = pgpsig_pkg::PH_TRAIL;
    end
  endfunction

  // Tag one byte and advance the model
  function automatic pgpsig_pkg::tag_t tag_byte(logic [7:0] b, logic last);
    pgpsig_pkg::tag_t t;
    bit               uh;
    logic [31:0]      len;
    t = '0;
    t.out_byte    = b;
    t.field_kind  = pgpsig_pkg::KIND_IGNORED;
    t.packet_done = last;
    uh = (sig_phase >= pgpsig_pkg::PH_USTART && sig_phase <= pgpsig_pkg::PH_UBODY);
    case (sig_phase)
      pgpsig_pkg::PH_VER: begin
        t.field_kind = pgpsig_pkg::KIND_VERSION;
        sig_phase    = pgpsig_pkg::PH_TYPE;
      end
      pgpsig_pkg::PH_TYPE: begin
        t.field_kind = pgpsig_pkg::KIND_TYPE;
        sig_phase    = pgpsig_pkg::PH_PK;
      end
      pgpsig_pkg::PH_PK: begin
        t.field_kind = pgpsig_pkg::KIND_PK_ALGO;
        pk_algo      = b;
        sig_phase    = pgpsig_pkg::PH_HASH;
      end
      pgpsig_pkg::PH_HASH: begin
        t.field_kind = pgpsig_pkg::KIND_HASH_ALGO;
        sig_phase    = pgpsig_pkg::PH_HLEN0;
      end
      pgpsig_pkg::PH_HLEN0, pgpsig_pkg::PH_ULEN0: begin
        uh           = (sig_phase == pgpsig_pkg::PH_ULEN0);
        t.field_kind = uh ? pgpsig_pkg::KIND_UNHASH_LEN : pgpsig_pkg::KIND_HASHED_LEN;
        area_rem     = {b, 8'h00};
        sig_phase    = uh ? pgpsig_pkg::PH_ULEN1 : pgpsig_pkg::PH_HLEN1;
      end
      pgpsig_pkg::PH_HLEN1, pgpsig_pkg::PH_ULEN1: begin
        uh           = (sig_phase == pgpsig_pkg::PH_ULEN1);
        t.field_kind = uh ? pgpsig_pkg::KIND_UNHASH_LEN : pgpsig_pkg::KIND_HASHED_LEN;
        area_rem     = area_rem | {8'h00, b};
        area_next(uh);
      end
      pgpsig_pkg::PH_FRAG0: begin
        t.field_kind = pgpsig_pkg::KIND_FRAGMENT;
        sig_phase    = pgpsig_pkg::PH_FRAG1;
      end
      pgpsig_pkg::PH_FRAG1: begin
        t.field_kind = pgpsig_pkg::KIND_FRAGMENT;
        if (pk_algo == pgpsig_pkg::ALG_RSA_ANY || pk_algo == pgpsig_pkg::ALG_RSA_SIGN ||
            pk_algo == pgpsig_pkg::ALG_DSA) begin
          mpi_idx   = 1'b0;
          sig_phase = pgpsig_pkg::PH_MLEN0;
        end else begin
          halt_parse(pgpsig_pkg::ERR_ALGO);
        end
      end
      pgpsig_pkg::PH_MLEN0: begin
        t.field_kind = pgpsig_pkg::KIND_MPI_LEN;
        t.mpi_number = mpi_idx;
        len_acc      = {16'h0, b, 8'h00};
        sig_phase    = pgpsig_pkg::PH_MLEN1;
      end
      pgpsig_pkg::PH_MLEN1: begin
        t.field_kind     = pgpsig_pkg::KIND_MPI_LEN;
        t.mpi_number     = mpi_idx;
        // bit count to byte count, rounded up
        len_acc          = ({16'h0, len_acc[15:8], b} + 32'd7) >> 3;
        mpi_rem          = len_acc[13:0];
        t.mpi_byte_count = len_acc[13:0];
        if (mpi_rem == 0) mpi_done();
        else sig_phase = pgpsig_pkg::PH_MDATA;
      end
      pgpsig_pkg::PH_MDATA: begin
        t.field_kind     = pgpsig_pkg::KIND_MPI_DATA;
        t.mpi_number     = mpi_idx;
        t.mpi_byte_count = len_acc[13:0];
        mpi_rem          = mpi_rem - 14'd1;
        if (mpi_rem == 0) mpi_done();
      end
      pgpsig_pkg::PH_HSTART, pgpsig_pkg::PH_HHDR2, pgpsig_pkg::PH_HHDR5,
      pgpsig_pkg::PH_HBODY, pgpsig_pkg::PH_USTART, pgpsig_pkg::PH_UHDR2,
      pgpsig_pkg::PH_UHDR5, pgpsig_pkg::PH_UBODY: begin
        area_rem = area_rem - 16'd1;
        if (sig_phase == pgpsig_pkg::PH_HBODY || sig_phase == pgpsig_pkg::PH_UBODY) begin
          t.field_kind       = uh ? pgpsig_pkg::KIND_UNHASH_BODY
                                  : pgpsig_pkg::KIND_HASHED_BODY;
          t.subpacket_length = len_acc;
          t.subpacket_first  = (sub_rem == len_acc);
          t.subpacket_end    = (sub_rem == 32'd1);
          sub_rem            = sub_rem - 32'd1;
          if (sub_rem == 0) area_next(uh);
        end else begin
          t.field_kind = uh ? pgpsig_pkg::KIND_UNHASH_HDR : pgpsig_pkg::KIND_HASHED_HDR;
          if (sig_phase == pgpsig_pkg::PH_HSTART || sig_phase == pgpsig_pkg::PH_USTART) begin
            if (b < pgpsig_pkg::LEN_TWO_MIN) begin
              t.subpacket_length = {24'h0, b};
              header_done(uh, {24'h0, b});
            end else if (b == pgpsig_pkg::LEN_FIVE_TAG) begin
              len_acc   = '0;
              len5_cnt  = '0;
              sig_phase = uh ? pgpsig_pkg::PH_UHDR5 : pgpsig_pkg::PH_HHDR5;
              if (area_rem == 0) halt_parse(pgpsig_pkg::ERR_OVERRUN);
            end else begin
              len_acc   = {16'h0, b - pgpsig_pkg::LEN_TWO_MIN, 8'h00};
              sig_phase = uh ? pgpsig_pkg::PH_UHDR2 : pgpsig_pkg::PH_HHDR2;
              if (area_rem == 0) halt_parse(pgpsig_pkg::ERR_OVERRUN);
            end
          end else if (sig_phase == pgpsig_pkg::PH_HHDR2 ||
                       sig_phase == pgpsig_pkg::PH_UHDR2) begin
            len = len_acc + {24'h0, b} + 32'd192;
            t.subpacket_length = len;
            header_done(uh, len);
          end else begin
            // five-octet form: four big-endian length bytes
            len_acc  = {len_acc[23:0], b};
            len5_cnt = len5_cnt + 3'd1;
            if (len5_cnt >= pgpsig_pkg::LEN_FIVE_CNT) begin
              t.subpacket_length = len_acc;
              header_done(uh, len_acc);
            end else if (area_rem == 0) begin
              halt_parse(pgpsig_pkg::ERR_OVERRUN);
            end
          end
        end
      end
      default: ;
    endcase
    if (last && sig_phase != pgpsig_pkg::PH_TRAIL && err_held == pgpsig_pkg::ERR_NONE)
      err_held = pgpsig_pkg::ERR_EARLY;
    t.error_code = err_held;
    if (last) reset_parse();
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pgpsig_pkg::tag_t mk_tag(logic [7:0] b, logic [3:0] kind,
                                              logic [1:0] err, logic done);
    pgpsig_pkg::tag_t t;
    t = '0;
    t.out_byte    = b;
    t.field_kind  = kind;
    t.error_code  = err;
    t.packet_done = done;
    return t;
  endfunction

  function automatic void add_row(logic [7:0] b, logic last);
    row_t r;
    r.b     = b;
    r.last  = last;
    r.fixed = 1'b0;
    r.want  = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_fixed(logic [7:0] b, logic last, pgpsig_pkg::tag_t want);
    row_t r;
    r.b     = b;
    r.last  = last;
    r.fixed = 1'b1;
    r.want  = want;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put(logic [7:0] b);
    pgpsig_pkg::byte_t x;
    x.in_byte   = b;
    x.body_last = 1'b0;
    pkt_q.insert(pkt_q.size(), x);
  endfunction

  function automatic void add_body(ref logic [7:0] body[$], input logic [7:0] b);
    body.insert(body.size(), b);
  endfunction

  // One subpacket area: length, then headers and bodies. A wild area ends
  // with a subpacket whose decoded length is random and usually too large.
  function automatic void put_area(bit wild);
    logic [7:0]  body[$];
    logic [31:0] wl;
    logic [15:0] alen;
    int          n, sl, enc, i;
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      enc = $urandom_range(0, 19);
      sl  = (enc == 0) ? $urandom_range(192, 200) : $urandom_range(0, 6);
      if (enc == 0) begin
        add_body(body, pgpsig_pkg::LEN_TWO_MIN);
        add_body(body, 8'(sl - 192));
      end else if (enc < 6) begin
        add_body(body, pgpsig_pkg::LEN_FIVE_TAG);
        add_body(body, 8'h00);
        add_body(body, 8'h00);
        add_body(body, 8'h00);
        add_body(body, 8'(sl));
      end else begin
        add_body(body, 8'(sl));
      end
      repeat (sl) add_body(body, rnd8());
    end
    if (wild) begin
      wl = $urandom();
      case ($urandom_range(0, 2))
        0: add_body(body, 8'($urandom_range(1, 191)));
        1: begin
          add_body(body, 8'($urandom_range(192, 254)));
          add_body(body, rnd8());
        end
        default: begin
          add_body(body, pgpsig_pkg::LEN_FIVE_TAG);
          add_body(body, wl[31:24]);
          add_body(body, wl[23:16]);
          add_body(body, wl[15:8]);
          add_body(body, wl[7:0]);
        end
      endcase
      repeat ($urandom_range(0, 3)) add_body(body, rnd8());
    end
    alen = 16'(body.size());
    if (wild && $urandom_range(0, 3) == 0) alen = 16'($urandom_range(0, 65535));
    put(alen[15:8]);
    put(alen[7:0]);
    foreach (body[j]) put(body[j]);
  endfunction

  // Signature packet body; big MPIs are cut short and so end early
  function automatic void build_sig(bit wild, bit big);
    logic [7:0] pk;
    int         bits, nb, n_mpi;
    put(($urandom_range(0, 15) == 0) ? rnd8() : 8'h04);
    put(rnd8());
    case ($urandom_range(0, 9))
      0:       pk = rnd8();
      1, 2, 3: pk = pgpsig_pkg::ALG_RSA_ANY;
      4, 5:    pk = pgpsig_pkg::ALG_RSA_SIGN;
      default: pk = pgpsig_pkg::ALG_DSA;
    endcase
    put(pk);
    put(rnd8());
    put_area(wild);
    put_area(wild);
    put(rnd8());
    put(rnd8());
    n_mpi = (pk == pgpsig_pkg::ALG_DSA) ? 2 : 1;
    repeat (n_mpi) begin
      if (big) bits = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
      else bits = $urandom_range(0, 72);
      put(8'(bits >> 8));
      put(8'(bits));
      nb = (bits + 7) / 8;
      if (big && nb > 12) nb = 12;
      repeat (nb) put(rnd8());
    end
    if (!big && !wild) repeat ($urandom_range(0, 2)) put(rnd8());
  endfunction

  // Offer one byte, wait for the transaction, queue its expected tag
  task automatic send_byte(logic [7:0] b, logic last, bit fixed,
                           pgpsig_pkg::tag_t fixed_tag);
    pgpsig_pkg::tag_t want;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    byte_valid          <= 1'b1;
    byte_data.in_byte   <= b;
    byte_data.body_last <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    want = tag_byte(b, last);
    n_sent++;
    if (fixed) want = fixed_tag;
    pending_tags.insert(pending_tags.size(), want);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    n_errors++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                n_results, name, got, want));
  endtask

  always @(posedge clk) begin
    pgpsig_pkg::tag_t want;
    if (!rst && tag_valid === 1'b1 && !tag_stall) begin
      if (pending_tags.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, byte %02h",
                                  tag_data.out_byte));
      end else begin
        want = pending_tags.pop_front();
        check_field("out_byte", 32'(tag_data.out_byte), 32'(want.out_byte));
        check_field("field_kind", 32'(tag_data.field_kind), 32'(want.field_kind));
        check_field("subpacket_length", tag_data.subpacket_length,
                    want.subpacket_length);
        check_field("subpacket_first", 32'(tag_data.subpacket_first),
                    32'(want.subpacket_first));
        check_field("subpacket_end", 32'(tag_data.subpacket_end),
                    32'(want.subpacket_end));
        check_field("mpi_number", 32'(tag_data.mpi_number), 32'(want.mpi_number));
        check_field("mpi_byte_count", 32'(tag_data.mpi_byte_count),
                    32'(want.mpi_byte_count));
        check_field("error_code", 32'(tag_data.error_code), 32'(want.error_code));
        check_field("packet_done", 32'(tag_data.packet_done), 32'(want.packet_done));
      end
      n_results++;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold-off to back up the parser
  // --------------------------------------------------------------------------
  initial begin
    int cyc;
    cyc = 0;
    repeat (6) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 1500) begin
        tag_stall <= 1'b1;
        repeat (300) @(posedge clk);
        tag_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        tag_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        tag_stall <= 1'b0;
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("pgp_signature_packet_parser_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int flavor, cut;
    reset_parse();

    // RSA, one empty subpacket, empty unhashed area, one MPI byte, trailer
    add_fixed(8'h04, 1'b0, mk_tag(8'h04, pgpsig_pkg::KIND_VERSION,
                                  pgpsig_pkg::ERR_NONE, 1'b0));
    add_fixed(8'h00, 1'b0, mk_tag(8'h00, pgpsig_pkg::KIND_TYPE,
                                  pgpsig_pkg::ERR_NONE, 1'b0));
    add_fixed(8'h01, 1'b0, mk_tag(8'h01, pgpsig_pkg::KIND_PK_ALGO,
                                  pgpsig_pkg::ERR_NONE, 1'b0));
    add_fixed(8'h08, 1'b0, mk_tag(8'h08, pgpsig_pkg::KIND_HASH_ALGO,
                                  pgpsig_pkg::ERR_NONE, 1'b0));
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hab, 1'b0);
    add_row(8'hcd, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h08, 1'b0);
    add_row(8'hff, 1'b0);
    add_fixed(8'h5a, 1'b1, mk_tag(8'h5a, pgpsig_pkg::KIND_IGNORED,
                                  pgpsig_pkg::ERR_NONE, 1'b1));
    // unknown algorithm, both areas empty, ends on the fragment
    add_row(8'hff, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hff, 1'b0);
    add_fixed(8'h00, 1'b1, mk_tag(8'h00, pgpsig_pkg::KIND_FRAGMENT,
                                  pgpsig_pkg::ERR_ALGO, 1'b1));
    // five-octet header cut off by a one-byte area; overrun is kept at the end
    add_row(8'h04, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h11, 1'b0);
    add_row(8'h0a, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_fixed(8'hff, 1'b1, mk_tag(8'hff, pgpsig_pkg::KIND_HASHED_HDR,
                                  pgpsig_pkg::ERR_OVERRUN, 1'b1));
    // body that ends on its first byte
    add_fixed(8'h04, 1'b1, mk_tag(8'h04, pgpsig_pkg::KIND_VERSION,
                                  pgpsig_pkg::ERR_EARLY, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i].b, plan[i].last, plan[i].fixed, plan[i].want);

    // random packets; no idling over the last stretch
    while (n_sent < 1950) begin
      pkt_q.delete();
      flavor = $urandom_range(0, 19);
      if (flavor < 13) begin
        build_sig(1'b0, 1'b0);
      end else if (flavor < 15) begin
        build_sig(1'b0, 1'b1);
      end else if (flavor < 17) begin
        build_sig(1'b1, 1'b0);
      end else if (flavor == 17) begin
        build_sig(1'b0, 1'b0);
        cut = $urandom_range(1, pkt_q.size());
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end else if (flavor == 18) begin
        build_sig(1'b0, 1'b0);
        pkt_q[$urandom_range(0, pkt_q.size() - 1)].in_byte = rnd8();
      end else begin
        repeat ($urandom_range(1, 12)) put(rnd8());
      end
      pkt_q[pkt_q.size() - 1].body_last = 1'b1;
      if (n_sent > 1750) idle_on = 1'b0;
      foreach (pkt_q[i]) send_byte(pkt_q[i].in_byte, pkt_q[i].body_last, 1'b0, '0);
    end
    byte_valid <= 1'b0;

    while (pending_tags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("pgp_signature_packet_parser_tb passed");
    end else begin
      $display("pgp_signature_packet_parser_tb failed");
    end
    $finish;
  end

endmodule
